[rtl/cid_pkg.sv]
// ----------------------------------------------------------------------------
// cid_pkg
// Shared types, constants and the first-byte decode for the compact integer
// decoder.
// ----------------------------------------------------------------------------
package cid_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned CountWidth = 3;

    // first-byte masks that strip the prefix bits
    localparam logic [ByteWidth-1:0] MaskU4    = 8'h3f;
    localparam logic [ByteWidth-1:0] MaskU2    = 8'h7f;
    localparam logic [ByteWidth-1:0] MaskSNeg4 = 8'h2f;
    localparam logic [ByteWidth-1:0] MaskSNeg2 = 8'h5f;
    localparam logic [ByteWidth-1:0] MaskSNeg1 = 8'hbf;

    // bytes still to come after the first byte
    localparam logic [CountWidth-1:0] RemainOne    = 3'd0;
    localparam logic [CountWidth-1:0] RemainTwo    = 3'd1;
    localparam logic [CountWidth-1:0] RemainFour   = 3'd3;
    localparam logic [CountWidth-1:0] RemainEscape = 3'd4;

    localparam logic StatusComplete  = 1'b0;
    localparam logic StatusTruncated = 1'b1;

    typedef struct packed {
        logic [CountWidth-1:0] remain;
        logic [ByteWidth-1:0]  first;
        logic                  negate;
    } first_byte_t;

    typedef struct packed {
        logic [ValueWidth-1:0] value;
        logic                  status;
    } result_t;

    function automatic first_byte_t decode_first(input logic [ByteWidth-1:0] b,
                                                 input logic sgn);
        first_byte_t d;
        d.remain = RemainOne;
        d.first  = b;
        d.negate = 1'b0;
        if (!sgn) begin
            unique case (b[7:5]) inside
                3'b111: begin
                    d.remain = RemainEscape;
                    d.first  = '0;
                end
                3'b110: begin
                    d.remain = RemainFour;
                    d.first  = b & MaskU4;
                end
                3'b100, 3'b101: begin
                    d.remain = RemainTwo;
                    d.first  = b & MaskU2;
                end
                default: begin
                    d.remain = RemainOne;
                    d.first  = b;
                end
            endcase
        end else begin
            unique case (b[7:4]) inside
                4'hf: begin
                    d.remain = RemainEscape;
                    d.first  = '0;
                    d.negate = 1'b1;
                end
                4'he: begin
                    d.remain = RemainEscape;
                    d.first  = '0;
                end
                4'hd: begin
                    d.remain = RemainFour;
                    d.first  = b & MaskSNeg4;
                    d.negate = 1'b1;
                end
                4'hc: begin
                    d.remain = RemainFour;
                    d.first  = b & MaskU4;
                end
                4'ha, 4'hb: begin
                    d.remain = RemainTwo;
                    d.first  = b & MaskSNeg2;
                    d.negate = 1'b1;
                end
                4'h8, 4'h9: begin
                    d.remain = RemainTwo;
                    d.first  = b & MaskU2;
                end
                4'h4, 4'h5, 4'h6, 4'h7: begin
                    d.remain = RemainOne;
                    d.first  = b & MaskSNeg1;
                    d.negate = 1'b1;
                end
                default: begin
                    d.remain = RemainOne;
                    d.first  = b;
                end
            endcase
        end
        return d;
    endfunction

endpackage

[rtl/compact_integer_decoder.sv]
// ----------------------------------------------------------------------------
// compact_integer_decoder
// Decodes big-endian prefix-length integers (1, 2, 4 or 5 bytes, unsigned or
// signed) from a byte stream, one result per completed or truncated value.
// ----------------------------------------------------------------------------
// results are registered on the beat ending a value (skid slot if m_ stalls)
// throughput: one byte per cycle while the skid slot is empty, set by the
// single-pass first-byte decode and shift accumulator; a two-entry output
// buffer keeps s_tready high while one result waits downstream
// reset: synchronous active-low aresetn empties the output buffer and returns
// the decoder to awaiting a first byte
module compact_integer_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] value_signed
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic        m_tuser    // [0] status
);

    logic [cid_pkg::CountWidth-1:0] bytes_left_reg, bytes_left_next;
    logic [cid_pkg::ValueWidth-1:0] acc_reg, acc_next;
    logic                           negate_reg, negate_next;

    logic             out_valid_reg, skid_valid_reg;
    cid_pkg::result_t out_data_reg, skid_data_reg;

    cid_pkg::first_byte_t           fb;
    cid_pkg::result_t               res;
    logic                           res_gen;
    logic                           beat;
    logic [cid_pkg::ValueWidth-1:0] acc_shift;
    logic [cid_pkg::ValueWidth-1:0] operand;
    logic                           operand_neg;
    logic [cid_pkg::CountWidth-1:0] left_dec;

    assign s_tready = !skid_valid_reg;
    assign beat     = s_tvalid && s_tready;
    assign fb       = cid_pkg::decode_first(s_tdata, s_tuser);
    assign acc_shift = {acc_reg[cid_pkg::ValueWidth-cid_pkg::ByteWidth-1:0], s_tdata};
    assign left_dec  = bytes_left_reg - cid_pkg::CountWidth'(1);

    always_comb begin
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        negate_next     = negate_reg;
        res_gen         = 1'b0;
        operand         = acc_shift;
        operand_neg     = negate_reg;
        res.status      = cid_pkg::StatusComplete;
        if (bytes_left_reg == '0) begin
            operand     = cid_pkg::ValueWidth'(fb.first);
            operand_neg = fb.negate;
            if (fb.remain == cid_pkg::RemainOne) begin
                res_gen = 1'b1;
            end else if (s_tlast) begin
                res_gen    = 1'b1;
                res.status = cid_pkg::StatusTruncated;
            end else begin
                bytes_left_next = fb.remain;
                acc_next        = cid_pkg::ValueWidth'(fb.first);
                negate_next     = fb.negate;
            end
        end else begin
            if (left_dec == '0) begin
                res_gen         = 1'b1;
                bytes_left_next = '0;
                negate_next     = 1'b0;
            end else if (s_tlast) begin
                res_gen         = 1'b1;
                res.status      = cid_pkg::StatusTruncated;
                bytes_left_next = '0;
                negate_next     = 1'b0;
            end else begin
                bytes_left_next = left_dec;
                acc_next        = acc_shift;
            end
        end
        if (res.status == cid_pkg::StatusTruncated) begin
            res.value = '0;
        end else begin
            res.value = operand_neg ? (cid_pkg::ValueWidth'(0) - operand) : operand;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            negate_reg     <= 1'b0;
        end else if (beat) begin
            bytes_left_reg <= bytes_left_next;
            negate_reg     <= negate_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat) begin
            acc_reg <= acc_next;
        end
    end

    // output register with a skid slot behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= beat && res_gen;
            end
        end else if (beat && res_gen) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end else if (beat && res_gen) begin
            skid_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.value;
    assign m_tuser  = out_data_reg.status;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full with output register empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg <= cid_pkg::RemainEscape)
        else $error("byte count out of range");

    a_idle_no_negate: assert property (@(posedge aclk) disable iff (!aresetn)
        (bytes_left_reg == '0) |-> !negate_reg)
        else $error("negate flag left set while awaiting first byte");

    a_truncated_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == cid_pkg::StatusTruncated) |-> (m_tdata == '0))
        else $error("truncated result carries a non-zero value");

    a_result_ends_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat && res_gen) |=> (bytes_left_reg == '0))
        else $error("result given but decoder not back to first byte");

endmodule
